@@ sv/aalf_pkg.sv @@
// ----------------------------------------------------------------------------
// aalf_pkg
// shared constants, register codes, controller states and command types
// ----------------------------------------------------------------------------
package aalf_pkg;

  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int STORE_SLOTS_DEF  = 1024;
  localparam int CODE_BITS_DEF    = 12;

  localparam int OUT_W      = 16;
  localparam int SLOT_OUT_W = 10;
  localparam int FRAC_W     = 16;
  localparam int CFG_W      = 16;

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int APB_IDX_LSB = 2;

  localparam logic [CFG_W-1:0] ALPHA_RST = 16'd25288;
  localparam logic [CFG_W-1:0] FS_RST    = 16'd33000;

  localparam int DIV_STEPS = OUT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [0:0] {
    REG_ALPHA = 1'b0,
    REG_FS    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DLOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

@@ sv/adc_average_lowpass_filter.sv @@
// ----------------------------------------------------------------------------
// adc_average_lowpass_filter
// sequence: accept, products in states mul1 to mul3, divider load, the
//   one-bit-per-cycle average divider (16 steps) and the result load, which
//   waits while a held result is stalled; one request at a time, the next
//   is accepted only after the result load
// reset: synchronous active-low; clears the window, sum, fill count,
//   low-pass state and slot counter, alpha to 25288 and full scale to 33000
// ----------------------------------------------------------------------------
module adc_average_lowpass_filter #(
  parameter int WINDOW_DEPTH = aalf_pkg::WINDOW_DEPTH_DEF,
  parameter int STORE_SLOTS  = aalf_pkg::STORE_SLOTS_DEF,
  parameter int CODE_BITS    = aalf_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [CODE_BITS-1:0]             in_adc_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [aalf_pkg::OUT_W-1:0]       out_raw_units,
  output logic [aalf_pkg::OUT_W-1:0]       out_average_units,
  output logic [aalf_pkg::OUT_W-1:0]       out_lowpass_units,
  output logic [aalf_pkg::SLOT_OUT_W-1:0]  out_store_slot,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aalf_pkg::APB_AW-1:0]      paddr,
  input  logic [aalf_pkg::APB_DW-1:0]      pwdata,
  output logic [aalf_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  aalf_pkg::cmd_t              cmd;
  aalf_pkg::sts_t              sts;
  logic [aalf_pkg::CFG_W-1:0]  alpha;
  logic [aalf_pkg::CFG_W-1:0]  fs;

  aalf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .alpha   (alpha),
    .fs      (fs)
  );

  aalf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  aalf_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .STORE_SLOTS  (STORE_SLOTS),
    .CODE_BITS    (CODE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_adc_code       (in_adc_code),
    .alpha             (alpha),
    .fs                (fs),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_raw_units     (out_raw_units),
    .out_average_units (out_average_units),
    .out_lowpass_units (out_lowpass_units),
    .out_store_slot    (out_store_slot)
  );

endmodule

@@ sv/aalf_regs.sv @@
// ----------------------------------------------------------------------------
// aalf_regs
// configuration registers behind the apb port: low-pass alpha and full scale
// ----------------------------------------------------------------------------
module aalf_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aalf_pkg::APB_AW-1:0]  paddr,
  input  logic [aalf_pkg::APB_DW-1:0]  pwdata,
  output logic [aalf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [aalf_pkg::CFG_W-1:0]   alpha,
  output logic [aalf_pkg::CFG_W-1:0]   fs
);

  aalf_pkg::reg_idx_t           idx;
  logic                         wr_en;
  logic [aalf_pkg::CFG_W-1:0]   alpha_r;
  logic [aalf_pkg::CFG_W-1:0]   fs_r;
  logic [aalf_pkg::CFG_W-1:0]   rd_val;

  assign idx    = aalf_pkg::reg_idx_t'(paddr[aalf_pkg::APB_IDX_LSB]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= aalf_pkg::ALPHA_RST;
      fs_r    <= aalf_pkg::FS_RST;
    end else if (wr_en) begin
      case (idx)
        aalf_pkg::REG_ALPHA: alpha_r <= pwdata[aalf_pkg::CFG_W-1:0];
        aalf_pkg::REG_FS:    fs_r    <= pwdata[aalf_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aalf_pkg::REG_ALPHA: rd_val = alpha_r;
      aalf_pkg::REG_FS:    rd_val = fs_r;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = aalf_pkg::APB_DW'(rd_val);
  assign alpha  = alpha_r;
  assign fs     = fs_r;

endmodule

@@ sv/aalf_div.sv @@
// ----------------------------------------------------------------------------
// aalf_div
// restoring divider, one quotient bit per step, quotient known to fit
// ----------------------------------------------------------------------------
module aalf_div #(
  parameter int DIVIDEND_W = 28,
  parameter int DIVISOR_W  = 12,
  parameter int QUO_W      = 16
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [QUO_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [QUO_W-1:0]     lo_r;
  logic [QUO_W-1:0]     lo_nxt;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fit;

  always_comb begin
    trial   = {rem_r, lo_r[QUO_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fit     = (trial >= {1'b0, dvs_r});
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    if (load) begin
      // upper part is already below the divisor
      rem_nxt = DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
      lo_nxt  = dividend[QUO_W-1:0];
    end else if (step) begin
      rem_nxt = fit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      lo_nxt  = {lo_r[QUO_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (load) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = lo_r;

endmodule

@@ sv/aalf_dp.sv @@
// ----------------------------------------------------------------------------
// aalf_dp
// datapath: averaging window, low-pass state, scaling products, dividers
// and the result register
// ----------------------------------------------------------------------------
module aalf_dp #(
  parameter int WINDOW_DEPTH = aalf_pkg::WINDOW_DEPTH_DEF,
  parameter int STORE_SLOTS  = aalf_pkg::STORE_SLOTS_DEF,
  parameter int CODE_BITS    = aalf_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aalf_pkg::cmd_t                   cmd,
  output aalf_pkg::sts_t                   sts,
  input  logic [CODE_BITS-1:0]             in_adc_code,
  input  logic [aalf_pkg::CFG_W-1:0]       alpha,
  input  logic [aalf_pkg::CFG_W-1:0]       fs,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [aalf_pkg::OUT_W-1:0]       out_raw_units,
  output logic [aalf_pkg::OUT_W-1:0]       out_average_units,
  output logic [aalf_pkg::OUT_W-1:0]       out_lowpass_units,
  output logic [aalf_pkg::SLOT_OUT_W-1:0]  out_store_slot
);

  localparam int FRAC_W  = aalf_pkg::FRAC_W;
  localparam int CFG_W   = aalf_pkg::CFG_W;
  localparam int OUT_W   = aalf_pkg::OUT_W;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SLOT_W  = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
  localparam int SUM_W   = CODE_BITS + FILL_W;
  localparam int Y_W     = CODE_BITS + FRAC_W;
  localparam int LPP_W   = Y_W + CFG_W + 2;
  localparam int RAWP_W  = CODE_BITS + CFG_W;
  localparam int AVGP_W  = SUM_W + CFG_W;
  localparam int LPFS_W  = Y_W + CFG_W;
  localparam int FOLD_W  = RAWP_W;

  typedef struct packed {
    logic [FOLD_W-1:0] rem;
    logic [OUT_W-1:0]  quo;
  } fold_t;

  logic [CODE_BITS-1:0]     code_max;
  logic [CODE_BITS-1:0]     code_r;
  logic [CODE_BITS-1:0]     old_r;
  logic [CODE_BITS-1:0]     win_r [WINDOW_DEPTH];
  logic [PTR_W-1:0]         ptr_r;
  logic [PTR_W-1:0]         ptr_nxt;
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_nxt;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         sum_nxt;
  logic [Y_W-1:0]           y_r;
  logic [Y_W-1:0]           y_nxt;
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_nxt;
  logic [SLOT_W-1:0]        slot_item_r;

  logic signed [Y_W:0]      diff_s;
  logic signed [CFG_W:0]    alpha_s;
  logic signed [LPP_W-1:0]  lp_prod_nxt;
  logic signed [LPP_W-1:0]  lp_prod_r;
  logic signed [Y_W+1:0]    lp_step;
  logic signed [Y_W+1:0]    y_sum;

  logic [RAWP_W-1:0]        raw_prod_r;
  logic [AVGP_W-1:0]        avg_prod_r;
  logic [LPFS_W-1:0]        lpfs_prod_r;
  logic [SUM_W-1:0]         avg_dvs;

  fold_t                    raw_fold_r;
  fold_t                    raw_fold_nxt;
  fold_t                    lp_fold_r;
  fold_t                    lp_fold_nxt;

  logic [OUT_W-1:0]         raw_q;
  logic [OUT_W-1:0]         avg_q;
  logic [OUT_W-1:0]         lp_q;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         raw_out_r;
  logic [OUT_W-1:0]         avg_out_r;
  logic [OUT_W-1:0]         lp_out_r;
  logic [aalf_pkg::SLOT_OUT_W-1:0] slot_out_r;

  // one folding step of a division by the top code 2^n - 1:
  // h*2^n + l equals h*(2^n - 1) + (h + l)
  function automatic fold_t fold_step(fold_t cur);
    logic [FOLD_W-CODE_BITS-1:0] hi;
    logic [CODE_BITS-1:0]        lo;
    fold_t                       res;
    hi  = cur.rem[FOLD_W-1:CODE_BITS];
    lo  = cur.rem[CODE_BITS-1:0];
    res = cur;
    if (hi != '0) begin
      res.rem = FOLD_W'(hi) + FOLD_W'(lo);
      res.quo = cur.quo + OUT_W'(hi);
    end else if (lo == '1) begin
      res.rem = '0;
      res.quo = cur.quo + 1'b1;
    end
    return res;
  endfunction

  assign code_max = '1;

  // window bookkeeping
  always_comb begin
    ptr_nxt  = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    fill_nxt = (fill_r < FILL_W'(WINDOW_DEPTH)) ? fill_r + 1'b1 : fill_r;
    slot_nxt = (slot_r == SLOT_W'(STORE_SLOTS - 1)) ? '0 : slot_r + 1'b1;
    sum_nxt  = sum_r - SUM_W'(old_r) + SUM_W'(code_r);
  end

  // low-pass step, floor of alpha * (x - y) / 2^16
  always_comb begin
    diff_s      = $signed({1'b0, code_r, FRAC_W'(0)}) - $signed({1'b0, y_r});
    alpha_s     = $signed({1'b0, alpha});
    lp_prod_nxt = alpha_s * diff_s;
    lp_step     = lp_prod_r[LPP_W-1:FRAC_W];
    y_sum       = $signed({2'b00, y_r}) + lp_step;
    y_nxt       = y_sum[Y_W-1:0];
  end

  assign avg_dvs = code_max * fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      y_r    <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.load) begin
        win_r[ptr_r] <= in_adc_code;
        ptr_r        <= ptr_nxt;
        fill_r       <= fill_nxt;
        slot_r       <= slot_nxt;
      end
      if (cmd.mul1) begin
        sum_r <= sum_nxt;
      end
      if (cmd.mul2) begin
        y_r <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r      <= in_adc_code;
      old_r       <= win_r[ptr_r];
      slot_item_r <= slot_r;
    end
    if (cmd.mul1) begin
      raw_prod_r <= code_r * fs;
      lp_prod_r  <= lp_prod_nxt;
    end
    if (cmd.mul2) begin
      avg_prod_r <= sum_r * fs;
    end
    if (cmd.mul3) begin
      lpfs_prod_r <= y_r * fs;
    end
  end

  // raw and low-pass readings: division by the top code by folding,
  // done well within the divider steps
  always_comb begin
    raw_fold_nxt = raw_fold_r;
    lp_fold_nxt  = lp_fold_r;
    if (cmd.div_load) begin
      raw_fold_nxt = '{rem: raw_prod_r, quo: '0};
      // fractional bits dropped first, then divided by the top code
      lp_fold_nxt  = '{rem: FOLD_W'(lpfs_prod_r[LPFS_W-1:FRAC_W]), quo: '0};
    end else if (cmd.div_step) begin
      raw_fold_nxt = fold_step(raw_fold_r);
      lp_fold_nxt  = fold_step(lp_fold_r);
    end
  end

  always_ff @(posedge clk) begin
    raw_fold_r <= raw_fold_nxt;
    lp_fold_r  <= lp_fold_nxt;
  end

  assign raw_q = raw_fold_r.quo;
  assign lp_q  = lp_fold_r.quo;

  aalf_div #(
    .DIVIDEND_W (AVGP_W),
    .DIVISOR_W  (SUM_W),
    .QUO_W      (OUT_W)
  ) u_div_avg (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (avg_prod_r),
    .divisor  (avg_dvs),
    .quotient (avg_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_out_r  <= raw_q;
      avg_out_r  <= avg_q;
      lp_out_r   <= lp_q;
      slot_out_r <= aalf_pkg::SLOT_OUT_W'(slot_item_r);
    end
  end

  assign sts.out_full      = out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_raw_units     = raw_out_r;
  assign out_average_units = avg_out_r;
  assign out_lowpass_units = lp_out_r;
  assign out_store_slot    = slot_out_r;

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= avg_dvs)
    else $error("window sum exceeds fill count times top code");

  a_lp_range: assert property (@(posedge clk) disable iff (!rst_n)
    y_r <= {code_max, FRAC_W'(0)})
    else $error("low-pass state out of range");

  a_fill_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == FILL_W'(WINDOW_DEPTH)) |=> (fill_r == FILL_W'(WINDOW_DEPTH)))
    else $error("fill count left saturation");

  a_fold_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> ((raw_fold_r.rem < FOLD_W'(code_max)) &&
                      (lp_fold_r.rem < FOLD_W'(code_max))))
    else $error("division by the top code not finished");
`endif

endmodule

@@ sv/aalf_ctrl.sv @@
// ----------------------------------------------------------------------------
// aalf_ctrl
// sequencer: accept, products in states mul1 to mul3, divider load and steps, result
// ----------------------------------------------------------------------------
module aalf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  aalf_pkg::sts_t  sts,
  output aalf_pkg::cmd_t  cmd
);

  aalf_pkg::state_t                state_r;
  aalf_pkg::state_t                state_nxt;
  logic [aalf_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [aalf_pkg::DIV_CNT_W-1:0]  cnt_nxt;
  logic                            div_last;
  logic                            out_free;

  assign div_last = (cnt_r == aalf_pkg::DIV_CNT_W'(aalf_pkg::DIV_STEPS - 1));
  assign out_free = !sts.out_full || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aalf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      aalf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = aalf_pkg::ST_MUL1;
        end
      end
      aalf_pkg::ST_MUL1:  state_nxt = aalf_pkg::ST_MUL2;
      aalf_pkg::ST_MUL2:  state_nxt = aalf_pkg::ST_MUL3;
      aalf_pkg::ST_MUL3:  state_nxt = aalf_pkg::ST_DLOAD;
      aalf_pkg::ST_DLOAD: state_nxt = aalf_pkg::ST_DIV;
      aalf_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = aalf_pkg::ST_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      aalf_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = aalf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aalf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      aalf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      aalf_pkg::ST_MUL1:  cmd.mul1     = 1'b1;
      aalf_pkg::ST_MUL2:  cmd.mul2     = 1'b1;
      aalf_pkg::ST_MUL3:  cmd.mul3     = 1'b1;
      aalf_pkg::ST_DLOAD: cmd.div_load = 1'b1;
      aalf_pkg::ST_DIV:   cmd.div_step = 1'b1;
      aalf_pkg::ST_HOLD:  cmd.out_load = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(sts.out_full && out_stall))
    else $error("result register overwritten while stalled");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aalf_pkg::ST_DIV && div_last) |=> (state_r == aalf_pkg::ST_HOLD))
    else $error("divide did not finish after its last step");
`endif

endmodule
